### hdl/tbo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_pkg
// Types, widths and register codes shared by the triangle/box overlap test.
// ----------------------------------------------------------------------------
package tbo_pkg;

  // Coordinates are signed Q12.12; the arithmetic is exact integer arithmetic.
  localparam int COORD_WIDTH = 24;
  localparam int INDEX_WIDTH = 16;

  localparam int HW  = COORD_WIDTH - 1;   // box half size
  localparam int VW  = COORD_WIDTH + 1;   // shifted vertex
  localparam int EW  = COORD_WIDTH + 2;   // edge
  localparam int PW  = EW + VW + 1;       // edge axis projection
  localparam int RW  = HW + EW + 1;       // edge axis radius
  localparam int NW  = 2 * EW + 1;        // normal component
  localparam int NLO = EW;                // low slice of a normal component
  localparam int NHI = NW - NLO;          // high slice of a normal component
  localparam int DW  = NW + VW + 4;       // normal projection and radius
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_X   = 3'd0,
    REG_HALF_Y   = 3'd1,
    REG_HALF_Z   = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vert_a_x;
    logic signed [COORD_WIDTH-1:0] vert_a_y;
    logic signed [COORD_WIDTH-1:0] vert_a_z;
    logic signed [COORD_WIDTH-1:0] vert_b_x;
    logic signed [COORD_WIDTH-1:0] vert_b_y;
    logic signed [COORD_WIDTH-1:0] vert_b_z;
    logic signed [COORD_WIDTH-1:0] vert_c_x;
    logic signed [COORD_WIDTH-1:0] vert_c_y;
    logic signed [COORD_WIDTH-1:0] vert_c_z;
    logic        [INDEX_WIDTH-1:0] face_index;
  } cmd_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] face_id;
    logic                   hit;
  } result_t;

  // Travels down the tag chain alongside the arithmetic.
  typedef struct packed {
    logic                   valid;
    logic [INDEX_WIDTH-1:0] id;
    logic                   sep;
  } tag_t;

endpackage
`default_nettype wire

### hdl/tbo_tag_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_tag_cell
// One stage of the tag chain: pass the tag on and fold in a separation flag.
// ----------------------------------------------------------------------------
module tbo_tag_cell
  import tbo_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  tag_t tag_in,
  input  wire  logic sep_in,
  output tag_t       tag_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
    tag_out.id  <= tag_in.id;
    tag_out.sep <= tag_in.sep | sep_in;
  end

endmodule
`default_nettype wire

### hdl/tbo_edge_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_edge_cell
// Separation test on one edge-by-box-axis cross product, three stages.
// ----------------------------------------------------------------------------
module tbo_edge_cell
  import tbo_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic signed [EW-1:0] eb,
  input  wire logic signed [EW-1:0] ec,
  input  wire logic signed [VW-1:0] vb [3],
  input  wire logic signed [VW-1:0] vc [3],
  input  wire logic        [HW-1:0] hb,
  input  wire logic        [HW-1:0] hc,
  output logic                      sep
);

  logic        [EW-1:0]      eb_abs, ec_abs;
  logic signed [EW+VW-1:0]   m1 [3];
  logic signed [EW+VW-1:0]   m2 [3];
  logic        [HW+EW-1:0]   rh1, rh2;
  logic signed [PW-1:0]      p [3];
  logic        [RW-1:0]      r;
  logic signed [PW:0]        r_pos, r_neg;
  logic                      all_above, all_below;

  assign eb_abs = eb[EW-1] ? EW'(-eb) : EW'(eb);
  assign ec_abs = ec[EW-1] ? EW'(-ec) : EW'(ec);

  // Axis is (e_c, -e_b) on the two other box axes.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m1[k] <= ec * vb[k];
      m2[k] <= eb * vc[k];
    end
    rh1 <= hb * ec_abs;
    rh2 <= hc * eb_abs;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p[k] <= PW'(m1[k]) - PW'(m2[k]);
    end
    r <= RW'(rh1) + RW'(rh2);
  end

  assign r_pos = (PW+1)'($signed({1'b0, r}));
  assign r_neg = -r_pos;

  always_comb begin
    all_above = 1'b1;
    all_below = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!((PW+1)'(p[k]) > r_pos)) all_above = 1'b0;
      if (!((PW+1)'(p[k]) < r_neg)) all_below = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sep <= all_above | all_below;
  end

endmodule
`default_nettype wire

### hdl/tbo_normal_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbo_normal_unit
// Separation test on the triangle normal, six stages.
// ----------------------------------------------------------------------------
module tbo_normal_unit
  import tbo_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic signed [EW-1:0] e0 [3],
  input  wire logic signed [EW-1:0] e1 [3],
  input  wire logic signed [VW-1:0] v0 [3],
  input  wire logic        [HW-1:0] h  [3],
  output logic                      sep
);

  logic signed [2*EW-1:0]      q  [6];
  logic signed [NW-1:0]        n  [3];
  logic signed [VW-1:0]        va [3];
  logic signed [VW-1:0]        vb [3];
  logic        [NW-1:0]        n_abs [3];
  logic signed [NLO+VW:0]      pl [3];
  logic signed [NHI+VW-1:0]    ph [3];
  logic        [NLO+HW-1:0]    al [3];
  logic        [NHI+HW-1:0]    ah [3];
  logic signed [DW-1:0]        sl, sh, d;
  logic        [DW-2:0]        rl, rh, r;
  logic signed [DW-1:0]        r_pos;

  // Cross product partial products.
  always_ff @(posedge clk) begin
    q[0] <= e0[1] * e1[2];
    q[1] <= e0[2] * e1[1];
    q[2] <= e0[2] * e1[0];
    q[3] <= e0[0] * e1[2];
    q[4] <= e0[0] * e1[1];
    q[5] <= e0[1] * e1[0];
    va   <= v0;
  end

  always_ff @(posedge clk) begin
    n[0] <= NW'(q[0]) - NW'(q[1]);
    n[1] <= NW'(q[2]) - NW'(q[3]);
    n[2] <= NW'(q[4]) - NW'(q[5]);
    vb   <= va;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_abs[i] = n[i][NW-1] ? NW'(-n[i]) : NW'(n[i]);
    end
  end

  // All vertices project to the same value on the normal, so use the first.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pl[i] <= $signed({1'b0, n[i][NLO-1:0]}) * vb[i];
      ph[i] <= $signed(n[i][NW-1:NLO]) * vb[i];
      al[i] <= n_abs[i][NLO-1:0] * h[i];
      ah[i] <= n_abs[i][NW-1:NLO] * h[i];
    end
  end

  always_ff @(posedge clk) begin
    sl <= DW'(pl[0]) + DW'(pl[1]) + DW'(pl[2]);
    sh <= DW'(ph[0]) + DW'(ph[1]) + DW'(ph[2]);
    rl <= (DW-1)'(al[0]) + (DW-1)'(al[1]) + (DW-1)'(al[2]);
    rh <= (DW-1)'(ah[0]) + (DW-1)'(ah[1]) + (DW-1)'(ah[2]);
  end

  always_ff @(posedge clk) begin
    d <= (sh <<< NLO) + sl;
    r <= (rh << NLO) + rl;
  end

  assign r_pos = $signed({1'b0, r});

  always_ff @(posedge clk) begin
    sep <= (d > r_pos) || (d < -r_pos);
  end

endmodule
`default_nettype wire

### hdl/triangle_box_overlap_test_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_unit
// Separating-axis overlap test of one triangle against a box per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low. busy is high only during reset, so a new triangle may be
//   issued every cycle.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
//   cfg_ready is always high. Indexes 0..2 set the box half sizes, 3..5 the
//   mesh-minus-box offset; other indexes are dropped. Write only while idle.
//   Result channel: done is high for exactly one cycle with result holding
//   the echoed face index and the hit flag.
// Throughput: one triangle per cycle outside reset; the edge cells and the normal unit
//   each work on a fresh triangle every cycle, the normal unit setting the
//   depth of the chain.
// Reset: clears the configuration to zero and drops all transactions in
//   flight. The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_unit
  import tbo_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire cmd_t                   cmd,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COORD_WIDTH-1:0] cfg_data,
  output logic                        done,
  output result_t                     result
);

  localparam int NCELLS = 9;

  logic        [HW-1:0]          half   [3];
  logic signed [COORD_WIDTH-1:0] offset [3];

  logic signed [COORD_WIDTH-1:0] raw [3][3];
  logic signed [VW-1:0]          v1  [3][3];
  logic signed [VW-1:0]          v2  [3][3];
  logic signed [EW-1:0]          e2  [3][3];
  logic signed [EW-1:0]          hpos [3];
  logic signed [EW-1:0]          hneg [3];
  logic                          box_sep;
  logic                          edge_sep [9];
  logic                          edge_any;
  logic                          norm_sep;
  logic                          accept;

  tag_t tag     [NCELLS+1];
  logic sep_in  [NCELLS];

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        half[i]   <= '0;
        offset[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_X:   half[0]   <= cfg_data[HW-1:0];
        REG_HALF_Y:   half[1]   <= cfg_data[HW-1:0];
        REG_HALF_Z:   half[2]   <= cfg_data[HW-1:0];
        REG_OFFSET_X: offset[0] <= cfg_data;
        REG_OFFSET_Y: offset[1] <= cfg_data;
        REG_OFFSET_Z: offset[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign raw[0][0] = cmd.vert_a_x;
  assign raw[0][1] = cmd.vert_a_y;
  assign raw[0][2] = cmd.vert_a_z;
  assign raw[1][0] = cmd.vert_b_x;
  assign raw[1][1] = cmd.vert_b_y;
  assign raw[1][2] = cmd.vert_b_z;
  assign raw[2][0] = cmd.vert_c_x;
  assign raw[2][1] = cmd.vert_c_y;
  assign raw[2][2] = cmd.vert_c_z;

  // Stage 1: move the vertices so the box centre sits at the origin.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        v1[k][i] <= VW'(raw[k][i]) + VW'(offset[i]);
      end
    end
  end

  // Box axes: separated when every vertex lies beyond the same face.
  always_comb begin
    box_sep = 1'b0;
    for (int i = 0; i < 3; i++) begin
      hpos[i] = EW'($signed({1'b0, half[i]}));
      hneg[i] = -hpos[i];
      if ((EW'(v1[0][i]) > hpos[i]) && (EW'(v1[1][i]) > hpos[i]) &&
          (EW'(v1[2][i]) > hpos[i])) box_sep = 1'b1;
      if ((EW'(v1[0][i]) < hneg[i]) && (EW'(v1[1][i]) < hneg[i]) &&
          (EW'(v1[2][i]) < hneg[i])) box_sep = 1'b1;
    end
  end

  // Stage 2: edges, and hold the vertices for the axis cells.
  always_ff @(posedge clk) begin
    v2 <= v1;
    for (int i = 0; i < 3; i++) begin
      e2[0][i] <= EW'(v1[1][i]) - EW'(v1[0][i]);
      e2[1][i] <= EW'(v1[2][i]) - EW'(v1[1][i]);
      e2[2][i] <= EW'(v1[0][i]) - EW'(v1[2][i]);
    end
  end

  // Edge-by-axis cells, one per edge and box axis, each one lane of the row.
  for (genvar m = 0; m < 3; m++) begin : g_edge
    for (genvar j = 0; j < 3; j++) begin : g_axis
      localparam int B = (j + 1) % 3;
      localparam int C = (j + 2) % 3;
      logic signed [VW-1:0] vb [3];
      logic signed [VW-1:0] vc [3];
      for (genvar k = 0; k < 3; k++) begin : g_vert
        assign vb[k] = v2[k][B];
        assign vc[k] = v2[k][C];
      end
      tbo_edge_cell u_cell (
        .clk (clk),
        .eb  (e2[m][B]),
        .ec  (e2[m][C]),
        .vb  (vb),
        .vc  (vc),
        .hb  (half[B]),
        .hc  (half[C]),
        .sep (edge_sep[m*3+j])
      );
    end
  end

  always_comb begin
    edge_any = 1'b0;
    for (int a = 0; a < 9; a++) begin
      edge_any = edge_any | edge_sep[a];
    end
  end

  tbo_normal_unit u_normal (
    .clk (clk),
    .e0  (e2[0]),
    .e1  (e2[1]),
    .v0  (v2[0]),
    .h   (half),
    .sep (norm_sep)
  );

  // Tag chain: carry valid and face index, fold in each test as it lands.
  assign tag[0].valid = accept;
  assign tag[0].id    = cmd.face_index;
  assign tag[0].sep   = 1'b0;

  always_comb begin
    for (int c = 0; c < NCELLS; c++) begin
      sep_in[c] = 1'b0;
    end
    sep_in[1] = box_sep;
    sep_in[5] = edge_any;
    sep_in[8] = norm_sep;
  end

  for (genvar c = 0; c < NCELLS; c++) begin : g_tag
    tbo_tag_cell u_tag (
      .clk     (clk),
      .rst     (rst),
      .tag_in  (tag[c]),
      .sep_in  (sep_in[c]),
      .tag_out (tag[c+1])
    );
  end

  assign done           = tag[NCELLS].valid;
  assign result.face_id = tag[NCELLS].id;
  assign result.hit     = ~tag[NCELLS].sep;

endmodule
`default_nettype wire
